### hw/rtl/speed_ramp_generator_macros.svh
// Assertion macros for the speed ramp generator.
// Used by the top level; no other dependencies.
`ifndef SPEED_RAMP_GENERATOR_MACROS_SVH
`define SPEED_RAMP_GENERATOR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SRG_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("speed ramp generator: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define SRG_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("speed ramp generator: next-cycle check failed");

`endif

### hw/rtl/srg_pkg.sv
// Package for the speed ramp generator: widths, codes and shared types.
// No dependencies; used by every RTL file of the block.
`timescale 1ns / 1ps
package srg_pkg;

   localparam int DATA_W    = 32;
   localparam int STEP_W    = 31;
   localparam int DIVISOR_W = 20;
   localparam int CSR_IDX_W = 2;

   localparam logic [DIVISOR_W-1:0] DIVISOR_RESET = DIVISOR_W'(1000);

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_ACCELERATION = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DECELERATION = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DIVISOR      = 2'd2;

   typedef enum logic [1:0] {
      CMD_TICK       = 2'd0,
      CMD_LOAD_POS   = 2'd1,
      CMD_LOAD_SPEED = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      MOTION_CONSTANT = 2'd0,
      MOTION_ACCEL    = 2'd1,
      MOTION_DECEL    = 2'd2
   } motion_type;

   // Result of the shared divider, as seen by the sequencer.
   typedef struct packed {
      logic              done;
      logic [DATA_W-1:0] quotient;
      logic [DATA_W-1:0] remainder;
   } div_result_type;

endpackage

### hw/rtl/srg_divider.sv
// Iterative signed divider (truncating, as C) of a 32-bit value by a 20-bit divisor.
// Two quotient bits per cycle. Depends on srg_pkg.
`timescale 1ns / 1ps
module srg_divider
   import srg_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [DATA_W-1:0]    dividend,
   input  logic [DIVISOR_W-1:0] divisor,
   output div_result_type       result
);

   localparam int BITS_PER_CYCLE = 2;
   localparam int STEPS          = DATA_W / BITS_PER_CYCLE;
   localparam int CNT_W          = $clog2(STEPS);

   logic                 busy_ff;
   logic                 done_ff;
   logic [CNT_W-1:0]     count_ff;
   logic                 neg_ff;
   logic [DIVISOR_W-1:0] dvs_ff;
   logic [DIVISOR_W-1:0] rem_ff;
   logic [DATA_W-1:0]    quo_ff;
   logic [DIVISOR_W-1:0] rem_in;
   logic [DATA_W-1:0]    quo_in;

   // Restoring division, two dependent narrow steps per cycle.
   always_comb begin
      logic [DIVISOR_W:0] trial;
      rem_in = rem_ff;
      quo_in = quo_ff;
      for (int i = 0; i < BITS_PER_CYCLE; i++) begin
         trial  = {rem_in, quo_in[DATA_W-1]};
         quo_in = {quo_in[DATA_W-2:0], 1'b0};
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in    = DIVISOR_W'(trial - {1'b0, dvs_ff});
            quo_in[0] = 1'b1;
         end else begin
            rem_in = trial[DIVISOR_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff  <= 1'b1;
            count_ff <= '0;
         end else if (busy_ff) begin
            count_ff <= count_ff + 1'b1;
            if (count_ff == CNT_W'(STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         neg_ff <= dividend[DATA_W-1];
         quo_ff <= dividend[DATA_W-1] ? (DATA_W'(0) - dividend) : dividend;
         rem_ff <= '0;
         // A zero divisor behaves as a divisor of one.
         dvs_ff <= (divisor == '0) ? DIVISOR_W'(1) : divisor;
      end else if (busy_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   // Quotient and remainder both take the sign of the dividend.
   always_comb begin
      result.done      = done_ff;
      result.quotient  = neg_ff ? (DATA_W'(0) - quo_ff) : quo_ff;
      result.remainder = neg_ff ? (DATA_W'(0) - DATA_W'(rem_ff)) : DATA_W'(rem_ff);
   end

endmodule

### hw/rtl/speed_ramp_generator.sv
// Speed ramp generator: trapezoidal speed ramp with fractional accumulators.
// One transaction at a time; the two divisions of the shared two-bit-per-cycle
// divider set the tick time. Synchronous active-high reset clears speed,
// position, remainders and motion state, and restores the registers to
// acceleration 0, deceleration 0 and divisor 1000.
`timescale 1ns / 1ps
`include "speed_ramp_generator_macros.svh"
module speed_ramp_generator
   import srg_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   // Request channel.
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [63:0]          req_tdata,   // [31:0] target_speed, [63:32] load_value
   input  logic [1:0]           req_tuser,   // [1:0] command
   // Response channel.
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [71:0]          rsp_tdata,   // [31:0] speed, [63:32] position,
                                             // [65:64] motion_state, [71:66] zero
   // Configuration write port.
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [STEP_W-1:0]    csr_wdata
);

   // The sequencer walks one tick through the error evaluation, the update of
   // the speed remainder, the speed division, the snap check, and the
   // position division. Both divisions share a single divider.
   typedef enum logic [3:0] {
      S_IDLE,
      S_ERROR,
      S_STEP,
      S_SPEED_DIV,
      S_SPEED_WAIT,
      S_SNAP,
      S_POS_DIV,
      S_POS_WAIT,
      S_FINISH
   } state_type;

   state_type            state_ff;
   logic [STEP_W-1:0]    accel_ff;
   logic [STEP_W-1:0]    decel_ff;
   logic [DIVISOR_W-1:0] divisor_ff;

   logic [DATA_W-1:0]    speed_ff;
   logic [DATA_W-1:0]    speed_rem_ff;
   logic [DATA_W-1:0]    pos_ff;
   logic [DATA_W-1:0]    pos_rem_ff;
   motion_type           motion_ff;

   logic [DATA_W-1:0]    target_ff;
   logic                 err_pos_ff;
   logic                 err_neg_ff;
   logic                 grow_ff;

   logic                 rsp_tvalid_ff;
   logic [71:0]          rsp_tdata_ff;

   logic [DATA_W-1:0]    err;
   logic [DATA_W-1:0]    grow;
   logic [DATA_W-1:0]    mag_target;
   logic [DATA_W-1:0]    mag_speed;
   logic [DATA_W-1:0]    err2;
   logic                 snap;
   logic [DATA_W-1:0]    req_target;
   logic [DATA_W-1:0]    req_load;
   cmd_type              req_cmd;
   logic                 req_fire;

   logic                 div_start;
   logic [DATA_W-1:0]    div_dividend;
   div_result_type       div_result;

   assign req_target = req_tdata[31:0];
   assign req_load   = req_tdata[63:32];
   assign req_cmd    = cmd_type'(req_tuser);
   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // Speed error and the change in magnitude; the magnitude of the most
   // negative value wraps onto itself as a plain negation does.
   assign mag_target = target_ff[DATA_W-1] ? (DATA_W'(0) - target_ff) : target_ff;
   assign mag_speed  = speed_ff[DATA_W-1] ? (DATA_W'(0) - speed_ff) : speed_ff;
   assign err        = target_ff - speed_ff;
   assign grow       = mag_target - mag_speed;

   // After the speed division: has the speed reached or passed the target?
   assign err2 = target_ff - speed_ff;
   assign snap = (err_pos_ff && (err2[DATA_W-1] || (err2 == '0))) ||
                 (err_neg_ff && !err2[DATA_W-1]);

   assign div_start    = (state_ff == S_SPEED_DIV) || (state_ff == S_POS_DIV);
   assign div_dividend = (state_ff == S_SPEED_DIV) ? speed_rem_ff : pos_rem_ff;

   srg_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (divisor_ff),
      .result   (div_result)
   );

   // Configuration registers; an index beyond the list is ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         accel_ff   <= '0;
         decel_ff   <= '0;
         divisor_ff <= DIVISOR_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ACCELERATION: accel_ff   <= csr_wdata;
            CSR_DECELERATION: decel_ff   <= csr_wdata;
            CSR_DIVISOR:      divisor_ff <= csr_wdata[DIVISOR_W-1:0];
            default: ;
         endcase
      end
   end

   // Sequencer with the motion state and the response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         speed_ff      <= '0;
         speed_rem_ff  <= '0;
         pos_ff        <= '0;
         pos_rem_ff    <= '0;
         motion_ff     <= MOTION_CONSTANT;
         rsp_tvalid_ff <= 1'b0;
         err_pos_ff    <= 1'b0;
         err_neg_ff    <= 1'b0;
         grow_ff       <= 1'b0;
      end else begin
         // The finish state decides the valid flag itself when it is active.
         if (rsp_tvalid_ff && rsp_tready && (state_ff != S_FINISH)) begin
            rsp_tvalid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  target_ff <= req_target;
                  // Loads finish at once; an unused command changes nothing.
                  unique case (req_cmd)
                     CMD_TICK: begin
                        state_ff <= S_ERROR;
                     end
                     CMD_LOAD_POS: begin
                        pos_ff     <= req_load;
                        pos_rem_ff <= '0;
                        state_ff   <= S_FINISH;
                     end
                     CMD_LOAD_SPEED: begin
                        speed_ff     <= req_load;
                        speed_rem_ff <= '0;
                        state_ff     <= S_FINISH;
                     end
                     default: begin
                        state_ff <= S_FINISH;
                     end
                  endcase
               end
            end
            S_ERROR: begin
               err_pos_ff <= !err[DATA_W-1] && (err != '0);
               err_neg_ff <= err[DATA_W-1];
               grow_ff    <= !grow[DATA_W-1] && (grow != '0);
               state_ff   <= S_STEP;
            end
            S_STEP: begin
               // Acceleration while the magnitude grows, deceleration
               // otherwise, signed by the direction of the error.
               if (err_pos_ff || err_neg_ff) begin
                  motion_ff <= grow_ff ? MOTION_ACCEL : MOTION_DECEL;
                  if (err_pos_ff) begin
                     speed_rem_ff <= speed_rem_ff +
                                     DATA_W'(grow_ff ? accel_ff : decel_ff);
                  end else begin
                     speed_rem_ff <= speed_rem_ff -
                                     DATA_W'(grow_ff ? accel_ff : decel_ff);
                  end
               end else begin
                  motion_ff <= MOTION_CONSTANT;
               end
               state_ff <= S_SPEED_DIV;
            end
            S_SPEED_DIV: begin
               state_ff <= S_SPEED_WAIT;
            end
            S_SPEED_WAIT: begin
               if (div_result.done) begin
                  speed_ff     <= speed_ff + div_result.quotient;
                  speed_rem_ff <= div_result.remainder;
                  state_ff     <= S_SNAP;
               end
            end
            S_SNAP: begin
               if (snap) begin
                  speed_ff     <= target_ff;
                  speed_rem_ff <= '0;
                  motion_ff    <= MOTION_CONSTANT;
                  pos_rem_ff   <= pos_rem_ff + target_ff;
               end else begin
                  pos_rem_ff   <= pos_rem_ff + speed_ff;
               end
               state_ff <= S_POS_DIV;
            end
            S_POS_DIV: begin
               state_ff <= S_POS_WAIT;
            end
            S_POS_WAIT: begin
               if (div_result.done) begin
                  pos_ff     <= pos_ff + div_result.quotient;
                  pos_rem_ff <= div_result.remainder;
                  state_ff   <= S_FINISH;
               end
            end
            S_FINISH: begin
               // Wait here only while an earlier result is still unclaimed.
               if (!rsp_tvalid_ff || rsp_tready) begin
                  rsp_tvalid_ff <= 1'b1;
                  rsp_tdata_ff  <= {6'b0, motion_ff, pos_ff, speed_ff};
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   // A tick or load keeps the block busy for at least the following cycle.
   `SRG_ASSERT_NEXT(a_busy_after_accept, req_fire, !req_tready)
   // The divider only reports a result while the sequencer waits for it.
   `SRG_ASSERT_NOW(a_div_done_expected, div_result.done,
                   (state_ff == S_SPEED_WAIT) || (state_ff == S_POS_WAIT))
   // A new response only appears on leaving the finish state.
   `SRG_ASSERT_NOW(a_rsp_from_finish, $rose(rsp_tvalid_ff), $past(state_ff == S_FINISH))
   // A snap always leaves the motion state at constant speed.
   `SRG_ASSERT_NEXT(a_snap_constant, (state_ff == S_SNAP) && snap,
                    motion_ff == MOTION_CONSTANT)

endmodule

### verif/tb_speed_ramp_generator.sv
// Self-checking testbench for the speed ramp generator: directed and random command streams.
// It predicts every result from its own ramp model and compares speed, position and motion state.
// Depends on srg_pkg and the speed_ramp_generator RTL only.
`timescale 1ns / 1ps
module tb_speed_ramp_generator
   import srg_pkg::*;
();

   // The command field is two bits wide, so the fourth code must be exercised too.
   // The block ignores it.
   localparam logic [1:0] CMD_SPARE = 2'd3;

   // This limit leaves a generous margin over a healthy run.
   localparam int CYCLE_LIMIT = 600000;
   localparam int PRINT_LIMIT = 100;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_ITEMS = 150;

   typedef struct {
      logic [1:0]  cmd;
      logic [31:0] target;
      logic [31:0] load;
   } ramp_cmd_type;

   typedef struct {
      logic [31:0] speed;
      logic [31:0] position;
      motion_type  motion;
   } ramp_result_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [63:0]          req_tdata = '0;   // [31:0] target_speed, [63:32] load_value
   logic [1:0]           req_tuser = '0;   // [1:0] command
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [71:0]          rsp_tdata;        // [31:0] speed, [63:32] position,
                                           // [65:64] motion_state, [71:66] zero
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [STEP_W-1:0]    csr_wdata = '0;

   // Register copies, as written through the configuration port.
   logic [30:0] accel_reg;
   logic [30:0] decel_reg;
   logic [19:0] div_reg;

   // Ramp state, advanced once for every accepted transaction.
   logic [31:0] speed_now;
   logic [31:0] speed_frac;
   logic [31:0] pos_now;
   logic [31:0] pos_frac;
   motion_type  motion_now;

   ramp_cmd_type    pending_cmds[$];
   ramp_result_type expected_results[$];
   ramp_cmd_type    on_bus;
   ramp_result_type oldest;

   int  queued_count = 0;
   int  accepted_count = 0;
   int  checked_count = 0;
   int  mismatch_count = 0;
   int  setting_count = 0;
   int  cycle_count = 0;
   // While set, neither side inserts idle cycles.
   logic calm = 1'b0;

   speed_ramp_generator u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Ramp prediction
   // ---------------------------------------------------------------------

   function automatic longint as_long(input logic [31:0] x);
      return longint'($signed(x));
   endfunction

   // The magnitude of the most negative value wraps back to itself, as a
   // 32-bit negation does.
   function automatic logic [31:0] magnitude(input logic [31:0] x);
      return x[31] ? 32'd0 - x : x;
   endfunction

   // Division by the divisor register, truncating toward zero. The remainder
   // keeps the sign of the dividend. A divisor of zero behaves as one.
   function automatic logic [31:0] trunc_div(input logic [31:0] value,
                                              output logic [31:0] rem);
      longint d;
      longint v;
      longint q;
      d = (div_reg == '0) ? 64'sd1 : longint'(div_reg);
      v = as_long(value);
      q = v / d;
      rem = 32'(v % d);
      return 32'(q);
   endfunction

   function automatic ramp_result_type ramp_step(input logic [1:0] cmd,
                                                  input logic [31:0] target,
                                                  input logic [31:0] load);
      longint          err;
      longint          grow;
      longint          err2;
      logic [31:0]     step;
      logic [31:0]     rem;
      ramp_result_type res;
      case (cmd)
         CMD_LOAD_POS: begin
            pos_now = load;
            pos_frac = '0;
         end
         CMD_LOAD_SPEED: begin
            speed_now = load;
            speed_frac = '0;
         end
         CMD_TICK: begin
            err = as_long(target - speed_now);
            grow = as_long(magnitude(target) - magnitude(speed_now));
            if (err != 0) begin
               // Acceleration while the magnitude must grow, deceleration
               // otherwise; the step follows the sign of the speed error.
               step = (grow > 0) ? {1'b0, accel_reg} : {1'b0, decel_reg};
               motion_now = (grow > 0) ? MOTION_ACCEL : MOTION_DECEL;
               if (err > 0) begin
                  speed_frac = speed_frac + step;
               end else begin
                  speed_frac = speed_frac - step;
               end
            end else begin
               motion_now = MOTION_CONSTANT;
            end
            // The remainder is divided even with no error left, so a
            // left-over fraction can still move the speed.
            speed_now = speed_now + trunc_div(speed_frac, rem);
            speed_frac = rem;
            // Overshoot, or landing exactly on the target, snaps the speed.
            err2 = as_long(target - speed_now);
            if ((err > 0 && err2 <= 0) || (err < 0 && err2 >= 0)) begin
               speed_now = target;
               speed_frac = '0;
               motion_now = MOTION_CONSTANT;
            end
            pos_frac = pos_frac + speed_now;
            pos_now = pos_now + trunc_div(pos_frac, rem);
            pos_frac = rem;
         end
         CMD_SPARE: begin
         end
      endcase
      res.speed = speed_now;
      res.position = pos_now;
      res.motion = motion_now;
      return res;
   endfunction

   // ---------------------------------------------------------------------
   // Reporting
   // ---------------------------------------------------------------------

   // Every mismatch is counted; printing stops after a while to keep the
   // log readable when the block is badly broken.
   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT) begin
         $display("[%0t] %s: got %h, want %h (result %0d)", $time, what, got, want,
                  checked_count);
      end
   endtask

   // ---------------------------------------------------------------------
   // Request driver
   // ---------------------------------------------------------------------

   // The expectation is formed at the edge where the request transaction is
   // accepted, so it is always queued before its response can appear. A
   // presented item is held until it is taken; only then is the next one
   // chosen, or a gap inserted.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_results.push_back(ramp_step(on_bus.cmd, on_bus.target, on_bus.load));
            accepted_count++;
         end
         if (!req_tvalid || req_tready) begin
            if (pending_cmds.size() != 0 && (calm || $urandom_range(99) >= 35)) begin
               on_bus = pending_cmds.pop_front();
               req_tvalid <= 1'b1;
               req_tuser <= on_bus.cmd;
               req_tdata <= {on_bus.load, on_bus.target};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Response monitor
   // ---------------------------------------------------------------------

   // Outputs are sampled at the clock edge, before the block updates them,
   // and each response transaction is matched against the oldest expectation.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            checked_count++;
            if (expected_results.size() == 0) begin
               report_mismatch("response with nothing expected", rsp_tdata[31:0], '0);
            end else begin
               oldest = expected_results.pop_front();
               if (rsp_tdata[31:0] !== oldest.speed) begin
                  report_mismatch("speed", rsp_tdata[31:0], oldest.speed);
               end
               if (rsp_tdata[63:32] !== oldest.position) begin
                  report_mismatch("position", rsp_tdata[63:32], oldest.position);
               end
               if (rsp_tdata[65:64] !== oldest.motion) begin
                  report_mismatch("motion_state", 32'(rsp_tdata[65:64]),
                                  32'(oldest.motion));
               end
            end
         end
         rsp_tready <= calm || ($urandom_range(99) >= 35);
      end
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results still outstanding.",
                  CYCLE_LIMIT, expected_results.size());
         $display("Mismatches found");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------

   task automatic queue_cmd(input logic [1:0] cmd, input logic [31:0] target,
                            input logic [31:0] load);
      ramp_cmd_type c;
      c.cmd = cmd;
      c.target = target;
      c.load = load;
      pending_cmds.push_back(c);
      queued_count++;
   endtask

   // Register writes are back to back: the enable stays high across them and
   // is lowered once, after the last one, by configure.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [30:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_ACCELERATION: accel_reg = value;
         CSR_DECELERATION: decel_reg = value;
         CSR_DIVISOR:      div_reg = value[19:0];
         default: ;
      endcase
   endtask

   task automatic configure(input logic [30:0] accel, input logic [30:0] decel,
                            input logic [19:0] divisor);
      write_reg(CSR_ACCELERATION, accel);
      write_reg(CSR_DECELERATION, decel);
      write_reg(CSR_DIVISOR, 31'(divisor));
      @(posedge clock);
      csr_we <= 1'b0;
      setting_count++;
      // Items are queued away from the active edge.
      @(negedge clock);
   endtask

   // Block until every queued transaction has gone in and every response
   // has come back, so that the block is idle.
   task automatic drain();
      while (accepted_count != queued_count || expected_results.size() != 0) begin
         @(negedge clock);
      end
   endtask

   // Speed values: full range, small values that ramps actually reach,
   // values near either end of the range, and values near zero.
   function automatic logic [31:0] pick_speed();
      case ($urandom_range(3))
         0: return $urandom;
         1: return 32'($urandom_range(200000)) - 32'd100000;
         2: return $urandom_range(1) ? 32'h7fff_ffff - $urandom_range(255)
                                     : 32'h8000_0000 + $urandom_range(255);
         default: return ($urandom_range(3) == 0) ? 32'd0
                                                  : 32'($urandom_range(5000)) - 32'd2500;
      endcase
   endfunction

   // Mostly runs of ticks toward one set point, so that ramps climb, settle
   // and reverse; loads, single jumps and the spare code are mixed in.
   task automatic queue_random_phase(input int n_items);
      int          start;
      int          pick;
      logic [31:0] goal;
      start = queued_count;
      while (queued_count - start < n_items) begin
         pick = $urandom_range(99);
         if (pick < 70) begin
            goal = pick_speed();
            repeat ($urandom_range(2, 20)) queue_cmd(CMD_TICK, goal, $urandom);
         end else if (pick < 80) begin
            queue_cmd(CMD_LOAD_SPEED, $urandom, pick_speed());
         end else if (pick < 88) begin
            queue_cmd(CMD_LOAD_POS, $urandom, $urandom);
         end else if (pick < 93) begin
            queue_cmd(CMD_SPARE, $urandom, $urandom);
         end else begin
            queue_cmd(CMD_TICK, $urandom, $urandom);
         end
      end
   endtask

   initial begin
      accel_reg = '0;
      decel_reg = '0;
      div_reg = DIVISOR_RESET;
      speed_now = '0;
      speed_frac = '0;
      pos_now = '0;
      pos_frac = '0;
      motion_now = MOTION_CONSTANT;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed part. Steps of 3000.5 and 5000.7 per tick leave fractions
      // in the speed remainder.
      configure(31'd3000500, 31'd5000700, 20'd1000);
      queue_cmd(CMD_TICK, 32'd0, 32'hffff_ffff);           // no error: constant
      queue_cmd(CMD_TICK, 32'h7fff_ffff, 32'h0);           // largest target
      queue_cmd(CMD_TICK, 32'h7fff_ffff, 32'h0);
      queue_cmd(CMD_TICK, 32'h8000_0000, 32'h0);           // error wraps positive
      queue_cmd(CMD_LOAD_SPEED, 32'h0, 32'h8000_0000);     // most negative speed
      queue_cmd(CMD_TICK, 32'h8000_0000, 32'h0);           // zero error at the end
      queue_cmd(CMD_TICK, 32'd100, 32'h0);                 // magnitude of -2^31 wraps
      queue_cmd(CMD_LOAD_SPEED, 32'h0, 32'd5000);
      queue_cmd(CMD_TICK, -32'sd5000, 32'h0);              // reversal through zero
      queue_cmd(CMD_TICK, -32'sd5000, 32'h0);
      queue_cmd(CMD_TICK, -32'sd5000, 32'h0);
      queue_cmd(CMD_LOAD_POS, 32'hffff_ffff, 32'h7fff_ffff);
      queue_cmd(CMD_TICK, 32'd2000000, 32'h0);             // speed ramps up from -5000 near the top position
      queue_cmd(CMD_TICK, 32'd2000000, 32'h0);
      queue_cmd(CMD_LOAD_POS, 32'h0, 32'h8000_0000);
      queue_cmd(CMD_SPARE, 32'hffff_ffff, 32'hffff_ffff);  // ignored command
      queue_cmd(CMD_LOAD_SPEED, 32'h0, 32'h7fff_ffff);
      queue_cmd(CMD_TICK, 32'h7fff_ffff, 32'h0);
      queue_cmd(CMD_TICK, 32'h8000_0000, 32'h0);           // one step past the top
      queue_cmd(CMD_SPARE, 32'h0, 32'h0);
      queue_cmd(CMD_LOAD_SPEED, 32'h0, 32'h0);
      queue_cmd(CMD_TICK, 32'd1000000, 32'h0);             // leaves a remainder of 500
      drain();

      // A divisor of zero acts as one. The first tick has no error, but the
      // remainder left over above is still added to the speed.
      configure(31'd7, 31'd3, 20'd0);
      queue_cmd(CMD_TICK, speed_now, 32'h0);
      queue_cmd(CMD_TICK, 32'd50, 32'h0);
      queue_cmd(CMD_TICK, -32'sd50, 32'h0);
      queue_cmd(CMD_LOAD_POS, 32'h0, 32'd12345);
      queue_cmd(CMD_TICK, -32'sd50, 32'h0);
      drain();

      // Random part, one register setting per phase, the extremes first.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: configure(31'h7fff_ffff, 31'h7fff_ffff, 20'd1);
            1: configure(31'd0, 31'd0, 20'd1000000);
            2: configure(31'($urandom_range(1000, 100000000)),
                         31'($urandom_range(1000, 100000000)), 20'd1000);
            3: configure(31'($urandom), 31'($urandom), 20'($urandom_range(1, 1000000)));
            4: configure(31'($urandom_range(1, 2000000)), 31'($urandom_range(1, 2000000)),
                         20'($urandom_range(1, 1000)));
            5: configure(31'($urandom_range(1, 5000)), 31'($urandom_range(1, 5000)), 20'd1);
            6: configure(31'($urandom), 31'd0, 20'd1000000);
            default: configure(31'd0, 31'($urandom), 20'($urandom_range(1, 1000000)));
         endcase
         // One phase runs with both sides at full rate throughout.
         calm = (phase == 2);
         queue_random_phase(PHASE_ITEMS);
         drain();
         calm = 1'b0;
      end

      // Any stray response would appear within a tick time or so.
      repeat (60) @(negedge clock);

      $display("Sent %0d transactions under %0d register settings; %0d responses checked.",
               accepted_count, setting_count, checked_count);
      $display("Covered ticks, position and speed loads, the ignored code and divisor zero.");
      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
